### src/dts_pkg.sv
`default_nettype none
package dts_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // operation codes of an input transaction
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // register indexes (word address paddr[3:2])
  localparam logic [1:0] REG_SHORT_HALF = 2'd0;
  localparam logic [1:0] REG_LONG_HALF  = 2'd1;
  localparam logic [1:0] REG_PREAMBLE   = 2'd2;

  localparam logic [7:0] SHORT_HALF_RESET = 8'd115;
  localparam logic [7:0] LONG_HALF_RESET  = 8'd229;
  localparam logic [4:0] PREAMBLE_RESET   = 5'd16;
  localparam logic [7:0] FIRST_BIT_MASK   = 8'h80;

  typedef enum logic [1:0] {
    PH_PREAMBLE  = 2'd0,
    PH_SEPARATOR = 2'd1,
    PH_SENDBYTE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic line_level;
    logic half_start;
    logic bit_value;
    logic packet_start;
  } dts_result_t;

endpackage
`default_nettype wire

### src/dcc_track_signal_generator.sv
// A tick transaction passes the input register, then the result register, which
// registers its result; a byte write gives no result.
// Throughput: one transaction per cycle; a waiting result holds a tick in the input
// register, while a byte write never waits on the result side.
// Reset (synchronous, active high): configuration returns to 115/229/16, the
// sequencer restarts in preamble, both pipeline registers empty.
`default_nettype none
module dcc_track_signal_generator #(
  parameter int MAX_MESSAGE_BYTES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          operation,
  input  wire logic [2:0]                    byte_index,
  input  wire logic [7:0]                    byte_value,
  input  wire logic [3:0]                    message_length,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               line_level,
  output logic                               half_start,
  output logic                               bit_value,
  output logic                               packet_start,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dts_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [dts_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [dts_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready
);
  import dts_pkg::*;

  logic [7:0] short_half_period;
  logic [7:0] long_half_period;
  logic [4:0] preamble_bits;
  logic       cfg_write;

  logic       s1_valid;
  logic       s1_op;
  logic [2:0] s1_index;
  logic [7:0] s1_value;
  logic [3:0] s1_length;
  logic       fire;
  logic       tick;
  logic       wr_en;

  logic [3:0]  byte_pos;
  logic [7:0]  store_data;
  logic [3:0]  message_len;
  dts_result_t result;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_half_period <= SHORT_HALF_RESET;
      long_half_period  <= LONG_HALF_RESET;
      preamble_bits     <= PREAMBLE_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_SHORT_HALF: short_half_period <= pwdata[7:0];
        REG_LONG_HALF:  long_half_period  <= pwdata[7:0];
        REG_PREAMBLE:   preamble_bits     <= pwdata[4:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SHORT_HALF: prdata = CFG_DATA_W'(short_half_period);
      REG_LONG_HALF:  prdata = CFG_DATA_W'(long_half_period);
      REG_PREAMBLE:   prdata = CFG_DATA_W'(preamble_bits);
      default:        prdata = '0;
    endcase
  end

  // input register; a write never waits on the result side
  assign fire     = s1_valid && ((s1_op == OP_WRITE) || !out_valid || out_ready);
  assign in_ready = !s1_valid || fire;
  assign tick     = fire && (s1_op == OP_TICK);
  assign wr_en    = fire && (s1_op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op     <= operation;
      s1_index  <= byte_index;
      s1_value  <= byte_value;
      s1_length <= message_length;
    end
  end

  dts_msg_store #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (s1_index),
    .wr_value    (s1_value),
    .wr_length   (s1_length),
    .rd_pos      (byte_pos),
    .rd_data     (store_data),
    .message_len (message_len)
  );

  dts_sequencer u_seq (
    .clk               (clk),
    .rst               (rst),
    .tick              (tick),
    .short_half_period (short_half_period),
    .long_half_period  (long_half_period),
    .preamble_bits     (preamble_bits),
    .message_len       (message_len),
    .store_data        (store_data),
    .byte_pos          (byte_pos),
    .result            (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      line_level   <= result.line_level;
      half_start   <= result.half_start;
      bit_value    <= result.bit_value;
      packet_start <= result.packet_start;
    end
  end

endmodule
`default_nettype wire

### src/dts_msg_store.sv
`default_nettype none
module dts_msg_store #(
  parameter int MAX_MESSAGE_BYTES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire logic [2:0] wr_index,
  input  wire logic [7:0] wr_value,
  input  wire logic [3:0] wr_length,
  input  wire logic [3:0] rd_pos,
  output logic      [7:0] rd_data,
  output logic      [3:0] message_len
);
  import dts_pkg::*;

  localparam int IdxW = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
  localparam logic [4:0] MaxBytes = 5'(MAX_MESSAGE_BYTES);

  logic [7:0] store [MAX_MESSAGE_BYTES];
  logic       wr_ok;
  logic [3:0] len_clamped;

  assign wr_ok = wr_en && ({2'b00, wr_index} < MaxBytes);

  always_comb begin
    len_clamped = wr_length;
    if (wr_length == 4'd0) begin
      len_clamped = 4'd1;
    end else if ({1'b0, wr_length} > MaxBytes) begin
      len_clamped = MaxBytes[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      store[IdxW'(wr_index)] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_len <= 4'd1;
    end else if (wr_ok) begin
      message_len <= len_clamped;
    end
  end

  assign rd_data = ({1'b0, rd_pos} < MaxBytes) ? store[IdxW'(rd_pos)] : 8'h00;

endmodule
`default_nettype wire

### src/dts_sequencer.sv
`default_nettype none
module dts_sequencer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               tick,
  input  wire logic [7:0]         short_half_period,
  input  wire logic [7:0]         long_half_period,
  input  wire logic [4:0]         preamble_bits,
  input  wire logic [3:0]         message_len,
  input  wire logic [7:0]         store_data,
  output logic      [3:0]         byte_pos,
  output dts_pkg::dts_result_t    result
);
  import dts_pkg::*;

  logic       second_half, second_half_next;
  phase_t     phase, phase_next;
  logic [4:0] preamble_left, preamble_left_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] bit_mask, bit_mask_next;
  logic [3:0] byte_pos_next;
  logic [7:0] half_counter, half_counter_next;
  logic       long_bit, long_bit_next;

  logic [7:0] count_dec;
  logic       expire;
  logic       advance;
  logic [7:0] period;

  assign count_dec = half_counter - 8'd1;
  assign expire    = (count_dec == 8'd0);
  assign advance   = tick && expire && !second_half;

  // bit sequencer: step once at the start of every first half
  always_comb begin
    phase_next         = phase;
    preamble_left_next = preamble_left;
    shift_byte_next    = shift_byte;
    bit_mask_next      = bit_mask;
    byte_pos_next      = byte_pos;
    long_bit_next      = long_bit;
    if (advance) begin
      case (phase)
        PH_SEPARATOR: begin
          long_bit_next   = 1'b1;
          phase_next      = PH_SENDBYTE;
          bit_mask_next   = FIRST_BIT_MASK;
          shift_byte_next = store_data;
        end
        PH_SENDBYTE: begin
          long_bit_next = ~|(shift_byte & bit_mask);
          bit_mask_next = bit_mask >> 1;
          if (bit_mask_next == 8'h00) begin
            byte_pos_next = byte_pos + 4'd1;
            if (byte_pos_next >= message_len) begin
              phase_next         = PH_PREAMBLE;
              preamble_left_next = preamble_bits;
            end else begin
              phase_next = PH_SEPARATOR;
            end
          end
        end
        default: begin
          long_bit_next = 1'b0;
          phase_next    = PH_PREAMBLE;
          if (preamble_left <= 5'd1) begin
            preamble_left_next = 5'd0;
            phase_next         = PH_SEPARATOR;
            byte_pos_next      = 4'd0;
          end else begin
            preamble_left_next = preamble_left - 5'd1;
          end
        end
      endcase
    end
  end

  // half-period timer
  always_comb begin
    period = long_bit_next ? long_half_period : short_half_period;
    if (period == 8'd0) begin
      period = 8'd1;
    end
    second_half_next  = second_half;
    half_counter_next = count_dec;
    if (expire) begin
      second_half_next  = !second_half;
      half_counter_next = period;
    end
  end

  // outputs of the current tick
  always_comb begin
    result.line_level   = !second_half_next;
    result.half_start   = expire;
    result.bit_value    = !long_bit_next;
    result.packet_start = advance && (phase != PH_SEPARATOR) && (phase != PH_SENDBYTE)
                          && (preamble_left <= 5'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_half   <= 1'b0;
      phase         <= PH_PREAMBLE;
      preamble_left <= PREAMBLE_RESET;
      shift_byte    <= 8'h00;
      bit_mask      <= FIRST_BIT_MASK;
      byte_pos      <= 4'd0;
      half_counter  <= SHORT_HALF_RESET;
      long_bit      <= 1'b0;
    end else if (tick) begin
      second_half   <= second_half_next;
      phase         <= phase_next;
      preamble_left <= preamble_left_next;
      shift_byte    <= shift_byte_next;
      bit_mask      <= bit_mask_next;
      byte_pos      <= byte_pos_next;
      half_counter  <= half_counter_next;
      long_bit      <= long_bit_next;
    end
  end

endmodule
`default_nettype wire

### src/dts_checker.sv
`default_nettype none
module dts_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic line_level,
  input wire logic half_start,
  input wire logic bit_value,
  input wire logic packet_start
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid
      && $stable({line_level, half_start, bit_value, packet_start}))
    else $error("result changed while stalled");

  // a packet begins at the start of a first half, on a preamble one
  a_pkt_half: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_start |-> half_start && !line_level && bit_value)
    else $error("packet start outside a first-half boundary");

  // drop any result after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a packet start only comes with a half boundary
  a_level_turn: assert property (@(posedge clk) disable iff (rst)
    out_valid && !half_start |-> !packet_start)
    else $error("packet start without a half boundary");

endmodule

bind dcc_track_signal_generator dts_checker u_dts_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .line_level   (line_level),
  .half_start   (half_start),
  .bit_value    (bit_value),
  .packet_start (packet_start)
);
`default_nettype wire

### tb/dcc_track_signal_generator_tb.sv
`default_nettype none
module dcc_track_signal_generator_tb;
  import dts_pkg::*;

  localparam int MSG_BYTES = 8;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic operation;
  logic [2:0] byte_index;
  logic [7:0] byte_value;
  logic [3:0] message_length;
  logic out_valid;
  logic out_ready;
  logic line_level;
  logic half_start;
  logic bit_value;
  logic packet_start;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  dcc_track_signal_generator #(
    .MAX_MESSAGE_BYTES(MSG_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .byte_index(byte_index),
    .byte_value(byte_value),
    .message_length(message_length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .line_level(line_level),
    .half_start(half_start),
    .bit_value(bit_value),
    .packet_start(packet_start),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // signal predictor state
  logic [7:0] short_half;
  logic [7:0] long_half;
  logic [4:0] preamble_cfg;
  logic in_second_half;
  phase_t seq_phase;
  logic [4:0] preamble_remaining;
  logic [7:0] out_byte;
  logic [7:0] out_mask;
  logic [3:0] out_pos;
  logic [7:0] half_timer;
  logic sending_zero;
  logic [7:0] message_bytes[MSG_BYTES];
  logic [3:0] message_count;

  dts_result_t expected_track[$];

  int ticks_sent = 0;
  int writes_sent = 0;
  int results_checked = 0;
  int packets_expected = 0;
  int settings_used = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int hold_off_len = 0;
  int recv_stall_left = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic int pick_gap(bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic predict_line_tick();
    dts_result_t r;
    logic pkt;
    pkt = 1'b0;
    r.half_start = 1'b0;
    half_timer = half_timer - 8'd1;
    if (half_timer == 8'd0) begin
      r.half_start = 1'b1;
      if (in_second_half) begin
        in_second_half = 1'b0;
      end else begin
        in_second_half = 1'b1;
        // pick the next bit at the start of a first half
        case (seq_phase)
          PH_SEPARATOR: begin
            sending_zero = 1'b1;
            seq_phase = PH_SENDBYTE;
            out_mask = FIRST_BIT_MASK;
            out_byte = (out_pos < MSG_BYTES) ? message_bytes[out_pos[2:0]] : 8'd0;
          end
          PH_SENDBYTE: begin
            sending_zero = ((out_byte & out_mask) == 8'd0);
            out_mask = out_mask >> 1;
            if (out_mask == 8'd0) begin
              out_pos = out_pos + 4'd1;
              if (out_pos >= message_count) begin
                seq_phase = PH_PREAMBLE;
                preamble_remaining = preamble_cfg;
              end else begin
                seq_phase = PH_SEPARATOR;
              end
            end
          end
          default: begin
            sending_zero = 1'b0;
            seq_phase = PH_PREAMBLE;
            if (preamble_remaining <= 5'd1) begin
              preamble_remaining = 5'd0;
              seq_phase = PH_SEPARATOR;
              out_pos = 4'd0;
              pkt = 1'b1;
            end else begin
              preamble_remaining = preamble_remaining - 5'd1;
            end
          end
        endcase
      end
      half_timer = sending_zero ? long_half : short_half;
      if (half_timer == 8'd0) half_timer = 8'd1;
    end
    r.line_level = ~in_second_half;
    r.bit_value = ~sending_zero;
    r.packet_start = pkt;
    if (pkt) packets_expected++;
    expected_track.push_back(r);
  endtask

  task automatic latch_message_byte(logic [2:0] idx, logic [7:0] val, logic [3:0] len);
    message_bytes[idx] = val;
    if (len == 4'd0) len = 4'd1;
    else if (len > MSG_BYTES) len = 4'(MSG_BYTES);
    message_count = len;
  endtask

  task automatic note_mismatch(string what, dts_result_t want, dts_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at %0t: line %b/%b half %b/%b bit %b/%b pkt %b/%b (exp/got)",
               what, $realtime, want.line_level, got.line_level, want.half_start,
               got.half_start, want.bit_value, got.bit_value, want.packet_start,
               got.packet_start);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    dts_result_t got;
    dts_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = dts_result_t'({line_level, half_start, bit_value, packet_start});
      if (expected_track.size() == 0) begin
        want = '0;
        note_mismatch("no result pending", want, got);
      end else begin
        want = expected_track.pop_front();
        results_checked++;
        if (got.line_level !== want.line_level || got.half_start !== want.half_start ||
            got.bit_value !== want.bit_value || got.packet_start !== want.packet_start) begin
          note_mismatch("field", want, got);
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               idle_cycles, expected_track.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_len) @(negedge clk);
        hold_off_len = 0;
        out_ready <= 1'b1;
      end else begin
        if (recv_stall_left == 0) recv_stall_left = pick_gap(recv_idle);
        if (recv_stall_left > 0) begin
          out_ready <= 1'b0;
          recv_stall_left--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_item(logic op, logic [2:0] idx, logic [7:0] val, logic [3:0] len);
    int gap;
    gap = pick_gap(send_idle);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    byte_index <= idx;
    byte_value <= val;
    message_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_WRITE) begin
      latch_message_byte(idx, val, len);
      writes_sent++;
    end else begin
      predict_line_tick();
      ticks_sent++;
    end
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 3'($urandom), 8'($urandom), 4'($urandom));
  endtask

  task automatic send_random_item();
    if ($urandom_range(0, 11) == 0) send_item(OP_WRITE, 3'($urandom), 8'($urandom), 4'($urandom));
    else send_tick();
  endtask

  // drop valid and wait until the block has nothing in flight
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_track.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] reg_idx, logic [7:0] value);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom());
    word[7:0] = value;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({reg_idx, 2'b00});
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      REG_SHORT_HALF: short_half = word[7:0];
      REG_LONG_HALF: long_half = word[7:0];
      REG_PREAMBLE: preamble_cfg = word[4:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [7:0] s_half, logic [7:0] l_half, logic [4:0] pre);
    settle_block();
    write_register(REG_SHORT_HALF, s_half);
    write_register(REG_LONG_HALF, l_half);
    write_register(REG_PREAMBLE, {3'($urandom), pre});
    settings_used++;
  endtask

  task automatic apply_reset();
    short_half = SHORT_HALF_RESET;
    long_half = LONG_HALF_RESET;
    preamble_cfg = PREAMBLE_RESET;
    in_second_half = 1'b0;
    seq_phase = PH_PREAMBLE;
    preamble_remaining = PREAMBLE_RESET;
    out_byte = 8'd0;
    out_mask = FIRST_BIT_MASK;
    out_pos = 4'd0;
    half_timer = SHORT_HALF_RESET;
    sending_zero = 1'b0;
    message_count = 4'd1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  endtask

  // fill every store entry before any tick can fetch one
  task automatic test_store_load();
    logic [7:0] vals[MSG_BYTES];
    logic [3:0] lens[MSG_BYTES];
    vals = '{8'hFF, 8'h00, 8'h8D, 8'h1B, 8'hA5, 8'h5A, 8'h80, 8'h01};
    lens = '{4'd0, 4'd15, 4'd9, 4'd8, 4'd1, 4'd5, 4'd2, 4'd3};
    for (int i = 0; i < MSG_BYTES; i++) send_item(OP_WRITE, 3'(i), vals[i], lens[i]);
  endtask

  task automatic test_reset_timing();
    repeat (6) send_tick();
  endtask

  // periods of zero and one, a preamble of zero, and an unmapped register
  task automatic test_degenerate_settings();
    settle_block();
    write_register(REG_SHORT_HALF, 8'd1);
    write_register(REG_LONG_HALF, 8'd0);
    write_register(REG_PREAMBLE, 8'hE0);
    write_register(REG_UNUSED, 8'hFF);
    settings_used++;
    repeat (220) send_tick();
  endtask

  task automatic test_random_traffic();
    int unsigned short_set[5];
    int unsigned long_set[5];
    int unsigned pre_set[5];
    short_set = '{2, 3, 2, 255, 2};
    long_set = '{3, 5, 2, 2, 255};
    pre_set = '{1, 4, 31, 1, 1};
    for (int k = 0; k < 8; k++) begin
      if (k < 5) apply_settings(8'(short_set[k]), 8'(long_set[k]), 5'(pre_set[k]));
      else apply_settings(8'($urandom_range(2, 6)), 8'($urandom_range(2, 9)),
                          5'($urandom_range(1, 6)));
      for (int n = 0; n < 150; n++) begin
        if (n % 40 == 0) begin
          send_idle = ($urandom_range(0, 3) != 0);
          recv_idle = ($urandom_range(0, 3) != 0);
        end
        send_random_item();
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // hold the receiver off while items keep coming, then let it drain
  task automatic test_backpressure();
    apply_settings(8'd2, 8'd3, 5'd2);
    send_idle = 1'b0;
    hold_off_len = HOLD_OFF_CYCLES;
    repeat (60) send_random_item();
    settle_block();
    send_idle = 1'b1;
    repeat (60) send_random_item();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_TICK;
    byte_index = '0;
    byte_value = '0;
    message_length = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    apply_reset();
    test_store_load();
    test_reset_timing();
    test_degenerate_settings();
    test_random_traffic();
    test_backpressure();
    settle_block();
    $display("covered %0d timer ticks and %0d byte writes over %0d register settings",
             ticks_sent, writes_sent, settings_used);
    $display("checked %0d line samples, %0d packet starts, %0d mismatches",
             results_checked, packets_expected, mismatches);
    if (mismatches == 0 && expected_track.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
